FILE: sv/flmp_pkg.sv
package flmp_pkg;

  localparam int AddrW   = 32;
  localparam int BytesW  = 4;
  localparam int DataW   = 64;
  localparam int TagW    = 16;
  localparam int TimeW   = 64;
  localparam int LatW    = 16;
  localparam int MsizeW  = 17;
  localparam int CfgIdxW = 1;

  localparam int MaxAccessBytes = 8;

  localparam logic [CfgIdxW-1:0] CfgLatency = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMemSize = 1'b1;

  localparam logic [LatW-1:0]   LatencyRst = 16'd4;
  localparam logic [MsizeW-1:0] MemSizeRst = 17'h10000;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STS_RD_DONE  = 2'd0,
    STS_RD_FAULT = 2'd1,
    STS_WR_LIMIT = 2'd2,
    STS_Q_DROP   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_ACCESS,
    ST_STAGE,
    ST_NEXT,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic              is_write;
    logic [AddrW-1:0]  addr;
    logic [BytesW-1:0] bytes;
    logic [DataW-1:0]  data;
    logic [TagW-1:0]   tag;
    logic [TimeW-1:0]  ready_time;
  } q_entry_t;

  typedef struct packed {
    status_e           status;
    logic [AddrW-1:0]  addr;
    logic [BytesW-1:0] bytes;
    logic [DataW-1:0]  data;
    logic [TagW-1:0]   tag;
  } rsp_t;

  typedef struct packed {
    logic clear_step;
    logic in_ready;
    logic enqueue;
    logic tick_inc;
    logic stage_drop;
    logic start_access;
    logic access_step;
    logic stage_head;
    logic pop;
    logic flush;
  } flmp_cmd_t;

  typedef struct packed {
    logic  clear_last;
    logic  in_valid;
    mode_e in_mode;
    logic  q_empty;
    logic  q_full;
    logic  head_ready;
    logic  head_fault;
    logic  head_is_write;
    logic  access_done;
    logic  hold_valid;
    logic  out_free;
  } flmp_sts_t;

endpackage

FILE: sv/flmp_in_if.sv
interface flmp_in_if import flmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [AddrW-1:0]  access_address;
  logic [BytesW-1:0] access_bytes;
  logic [DataW-1:0]  write_data;
  logic [TagW-1:0]   request_tag;

  modport source (
    output valid, mode, access_address, access_bytes, write_data, request_tag,
    input  ready
  );
  modport sink (
    input  valid, mode, access_address, access_bytes, write_data, request_tag,
    output ready
  );
endinterface

FILE: sv/flmp_out_if.sv
interface flmp_out_if import flmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [AddrW-1:0]  done_address;
  logic [BytesW-1:0] done_bytes;
  logic [DataW-1:0]  read_data;
  logic [TagW-1:0]   done_tag;
  logic              last;

  modport source (
    output valid, status, done_address, done_bytes, read_data, done_tag, last,
    input  ready
  );
  modport sink (
    input  valid, status, done_address, done_bytes, read_data, done_tag, last,
    output ready
  );
endinterface

FILE: sv/flmp_ctrl.sv
module flmp_ctrl import flmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  flmp_sts_t sts_i,
  output flmp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          case (sts_i.in_mode)
            MODE_TICK: begin
              cmd_o.tick_inc = 1'b1;
              state_d        = ST_CHECK;
            end
            MODE_READ, MODE_WRITE: begin
              if (sts_i.q_full) begin
                cmd_o.stage_drop = 1'b1;
                state_d          = ST_FLUSH;
              end else begin
                cmd_o.enqueue = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (!sts_i.head_ready) begin
          state_d = sts_i.hold_valid ? ST_FLUSH : ST_IDLE;
        end else if (sts_i.head_fault) begin
          state_d = ST_STAGE;
        end else begin
          cmd_o.start_access = 1'b1;
          state_d            = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.access_step = 1'b1;
        if (sts_i.access_done) begin
          if (sts_i.head_is_write) begin
            cmd_o.pop = 1'b1;
            state_d   = ST_NEXT;
          end else begin
            state_d = ST_STAGE;
          end
        end
      end
      ST_STAGE: begin
        // the held beat moves out first, so wait for room when one is held
        if (!sts_i.hold_valid || sts_i.out_free) begin
          cmd_o.stage_head = 1'b1;
          cmd_o.pop        = 1'b1;
          state_d          = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_d = ST_CHECK;
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/flmp_datapath.sv
module flmp_datapath import flmp_pkg::*; #(
  parameter int MEM_BYTES   = 65536,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  flmp_in_if.sink           in_i,
  flmp_out_if.source        out_o,
  input  logic [LatW-1:0]   latency_i,
  input  logic [AddrW:0]    limit_i,
  input  flmp_cmd_t         cmd_i,
  output flmp_sts_t         sts_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [AW-1:0] MemLast = AW'(MEM_BYTES - 1);
  localparam logic [QW-1:0] QLast   = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] QDepth  = CW'(QUEUE_DEPTH);
  localparam logic [QW:0]   QDepthW = (QW + 1)'(QUEUE_DEPTH);

  // clearing pass and tick counter
  logic [AW-1:0]    clr_q;
  logic [TimeW-1:0] tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      tick_q <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.tick_inc) begin
        tick_q <= tick_q + 1'b1;
      end
    end
  end

  // request queue
  q_entry_t          q_mem [QUEUE_DEPTH];
  q_entry_t          head_ent_q;
  q_entry_t          new_ent;
  logic [QW-1:0]     head_q;
  logic [CW-1:0]     cnt_q;
  logic [QW:0]       tail_sum;
  logic [QW-1:0]     tail;
  logic [QW-1:0]     head_next;
  logic [BytesW-1:0] in_bytes_sat;

  assign in_bytes_sat = (in_i.access_bytes > BytesW'(MaxAccessBytes)) ?
                        BytesW'(MaxAccessBytes) : in_i.access_bytes;

  assign tail_sum  = (QW + 1)'(head_q) + (QW + 1)'(cnt_q);
  assign tail      = (tail_sum >= QDepthW) ? QW'(tail_sum - QDepthW) : QW'(tail_sum);
  assign head_next = (head_q == QLast) ? '0 : head_q + 1'b1;

  always_comb begin
    new_ent.is_write   = (mode_e'(in_i.mode) == MODE_WRITE);
    new_ent.addr       = in_i.access_address;
    new_ent.bytes      = in_bytes_sat;
    new_ent.data       = in_i.write_data;
    new_ent.tag        = in_i.request_tag;
    new_ent.ready_time = tick_q + TimeW'(latency_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enqueue) begin
      q_mem[tail] <= new_ent;
    end
    head_ent_q <= q_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.enqueue) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.pop) begin
      head_q <= head_next;
      cnt_q  <= cnt_q - 1'b1;
    end
  end

  // head decode
  logic [AddrW:0] head_end;
  logic           head_fault;
  logic           head_ready;

  assign head_end   = {1'b0, head_ent_q.addr} + (AddrW + 1)'(head_ent_q.bytes);
  assign head_fault = head_end > limit_i;
  assign head_ready = (cnt_q != '0) && !(head_ent_q.ready_time > tick_q);

  // byte memory, one byte a cycle
  logic [7:0]        mem [MEM_BYTES];
  logic [7:0]        rd_q;
  logic [AW-1:0]     mem_addr;
  logic [AddrW-1:0]  byte_addr;
  logic [7:0]        mem_wdata;
  logic              mem_we;
  logic              mem_re;
  logic              acc_live;
  logic [BytesW-1:0] acc_cnt_q;
  logic              cap_vld_q;
  logic [2:0]        cap_idx_q;
  logic [DataW-1:0]  asm_q;

  assign byte_addr = head_ent_q.addr + AddrW'(acc_cnt_q);
  assign mem_addr  = cmd_i.clear_step ? clr_q : byte_addr[AW-1:0];
  assign acc_live  = cmd_i.access_step && (acc_cnt_q < head_ent_q.bytes);
  assign mem_we    = cmd_i.clear_step || (acc_live && head_ent_q.is_write);
  assign mem_re    = acc_live && !head_ent_q.is_write;
  assign mem_wdata = cmd_i.clear_step ? 8'h00 :
                     head_ent_q.data[{acc_cnt_q[2:0], 3'b000} +: 8];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q <= '0;
      cap_vld_q <= 1'b0;
    end else if (cmd_i.start_access) begin
      acc_cnt_q <= '0;
      cap_vld_q <= 1'b0;
    end else begin
      if (acc_live) begin
        acc_cnt_q <= acc_cnt_q + 1'b1;
      end
      cap_vld_q <= mem_re;
    end
  end

  // gather read bytes in the cycle after the issue
  always_ff @(posedge clk_i) begin
    cap_idx_q <= acc_cnt_q[2:0];
    if (cmd_i.start_access) begin
      asm_q <= '0;
    end else if (cap_vld_q) begin
      asm_q[{cap_idx_q, 3'b000} +: 8] <= rd_q;
    end
  end

  // hold stage: keeps the newest result until its last flag is known
  rsp_t head_rsp;
  rsp_t drop_rsp;
  rsp_t hold_q;
  logic hold_vld_q;
  rsp_t out_q;
  logic out_last_q;
  logic out_vld_q;
  logic out_load;

  always_comb begin
    head_rsp.addr  = head_ent_q.addr;
    head_rsp.bytes = head_ent_q.bytes;
    head_rsp.tag   = head_ent_q.is_write ? '0 : head_ent_q.tag;
    head_rsp.data  = head_fault ? '0 : asm_q;
    if (!head_fault) begin
      head_rsp.status = STS_RD_DONE;
    end else if (head_ent_q.is_write) begin
      head_rsp.status = STS_WR_LIMIT;
    end else begin
      head_rsp.status = STS_RD_FAULT;
    end
    drop_rsp.status = STS_Q_DROP;
    drop_rsp.addr   = in_i.access_address;
    drop_rsp.bytes  = in_bytes_sat;
    drop_rsp.data   = '0;
    drop_rsp.tag    = in_i.request_tag;
  end

  assign out_load = (cmd_i.stage_head && hold_vld_q) || cmd_i.flush;

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_head) begin
      hold_q <= head_rsp;
    end else if (cmd_i.stage_drop) begin
      hold_q <= drop_rsp;
    end
    if (out_load) begin
      out_q      <= hold_q;
      out_last_q <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.stage_head || cmd_i.stage_drop) begin
        hold_vld_q <= 1'b1;
      end else if (cmd_i.flush) begin
        hold_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign in_i.ready         = cmd_i.in_ready;
  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_q.status;
  assign out_o.done_address = out_q.addr;
  assign out_o.done_bytes   = out_q.bytes;
  assign out_o.read_data    = out_q.data;
  assign out_o.done_tag     = out_q.tag;
  assign out_o.last         = out_last_q;

  always_comb begin
    sts_o.clear_last    = (clr_q == MemLast);
    sts_o.in_valid      = in_i.valid;
    sts_o.in_mode       = mode_e'(in_i.mode);
    sts_o.q_empty       = (cnt_q == '0);
    sts_o.q_full        = (cnt_q == QDepth);
    sts_o.head_ready    = head_ready;
    sts_o.head_fault    = head_fault;
    sts_o.head_is_write = head_ent_q.is_write;
    sts_o.access_done   = (acc_cnt_q == head_ent_q.bytes) && !cap_vld_q;
    sts_o.hold_valid    = hold_vld_q;
    sts_o.out_free      = !out_vld_q || out_o.ready;
  end

endmodule

FILE: sv/fixed_latency_memory_port.sv
// Byte memory of MEM_BYTES bytes behind an in-order queue of QUEUE_DEPTH
// requests. A read or write request is taken and stamped with the tick count
// plus the latency register; a full queue drops it and answers with a drop
// beat that passes through the hold and output registers. A tick item
// advances the tick count, drains every ready entry at the head, then
// flushes its last beat when it returns any. The drain is set by the
// single-port byte memory, which moves one byte a cycle. A stalled output
// holds the drain and the flush until room opens.
// Successful writes return nothing; reads, faults and drops return one beat
// each, the last beat of an item carrying last. Results wait in an output
// register, and a new item is taken once the previous one has all its beats
// staged there. After reset the whole memory is cleared to zero, during
// which no item is taken; configuration writes are taken at any time.
module fixed_latency_memory_port import flmp_pkg::*; #(
  parameter int MEM_BYTES   = 65536,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  flmp_in_if.sink             in_i,
  flmp_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [MsizeW-1:0]   cfg_data_i
);

  localparam logic [AddrW:0] MemBytesW = (AddrW + 1)'(MEM_BYTES);

  logic [LatW-1:0]   latency_q;
  logic [MsizeW-1:0] msize_q;
  logic [AddrW:0]    msize_w;
  logic [AddrW:0]    limit;
  flmp_cmd_t         cmd;
  flmp_sts_t         sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latency_q <= LatencyRst;
      msize_q   <= MemSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLatency: latency_q <= cfg_data_i[LatW-1:0];
        CfgMemSize: msize_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign msize_w = (AddrW + 1)'(msize_q);
  assign limit   = (msize_w < MemBytesW) ? msize_w : MemBytesW;

  flmp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  flmp_datapath #(
    .MEM_BYTES   (MEM_BYTES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .latency_i (latency_q),
    .limit_i   (limit),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

  // no held beat may be left behind when a new item is taken
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.in_ready |-> !sts.hold_valid)
    else $error("item taken while a result is still held");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.q_empty)
    else $error("pop from an empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enqueue |-> !sts.q_full)
    else $error("push into a full queue");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.stage_head && sts.hold_valid) || cmd.flush |-> sts.out_free)
    else $error("output beat overwritten before it was taken");

endmodule
